// ===== rtl/mersenne_twister_seed_stack_top_defines.svh =====
// Assertion macros for the seed stack RTL.
// No dependencies; taken in by the modules that carry assertions.
`ifndef MERSENNE_TWISTER_SEED_STACK_TOP_DEFINES_SVH
`define MERSENNE_TWISTER_SEED_STACK_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MTS_ASSERT_IMPLY(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("implication check failed");
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("next-cycle check failed");
`else
`define MTS_ASSERT_IMPLY(lbl, clk, rst_n, a, b)
`define MTS_ASSERT_NEXT(lbl, clk, rst_n, a, b)
`endif
`endif

// ===== rtl/mts_pkg.sv =====
// Shared types and constants for the seed stack.
// No dependencies.
`timescale 1ns / 1ps
package mts_pkg;
    localparam int STATE_WORDS = 624;
    localparam int STACK_SLOTS = 16;
    localparam int IDX_W = 10;
    localparam int SLOT_W = 4;
    localparam int ADDR_W = SLOT_W + IDX_W;
    localparam int SHIFT_OFS = 397;
    localparam int INIT_TWISTS = 20;
    localparam logic [31:0] TWIST_A = 32'h9908B0DF;
    localparam logic [31:0] HI_MASK = 32'h80000000;
    localparam logic [31:0] LO_MASK = 32'h7FFFFFFF;
    localparam logic [31:0] SEED_MUL = 32'd1812433253;
    localparam logic [15:0] DEPTH_MAX = 16'hFFFF;

    localparam logic [2:0] REQ_DRAW = 3'd0;
    localparam logic [2:0] REQ_INIT = 3'd1;
    localparam logic [2:0] REQ_PUSH1 = 3'd2;
    localparam logic [2:0] REQ_PUSH2 = 3'd3;
    localparam logic [2:0] REQ_PUSH3 = 3'd4;
    localparam logic [2:0] REQ_POP = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_PAIR_SUM, S_PAIR_MUL, S_PAIR_ADD, S_SEED_INIT,
        S_SEED_MUL, S_SEED_WR, S_TW_LD, S_TW_CUR, S_TW_RD, S_TW_WR,
        S_DRAW_RD, S_DRAW_OUT, S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic decode;
        logic pop;
        logic pair_sum;
        logic pair_mul;
        logic pair_add;
        logic seed_init;
        logic seed_mul;
        logic seed_wr;
        logic tw_ld;
        logic tw_cur;
        logic tw_rd;
        logic tw_wr;
        logic rp_clear;
        logic draw_rd;
        logic finish;
        logic finish_draw;
    } t_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       exhausted;
        logic       pair_again;
        logic       idx_last;
        logic       twists_last;
    } t_stat;

    function automatic logic [SLOT_W-1:0] clamp_slot(input logic [15:0] depth);
        logic [SLOT_W-1:0] res;
        if (depth >= 16'(STACK_SLOTS)) res = SLOT_W'(STACK_SLOTS - 1);
        else res = depth[SLOT_W-1:0];
        return res;
    endfunction
endpackage

// ===== rtl/mersenne_twister_seed_stack_top.sv =====
// Top level of the seed stack: controller plus datapath.
// Depends on mts_pkg, mts_ctrl and mts_dp.
`timescale 1ns / 1ps
// One transaction at a time: start is taken while busy is low, and exactly one
// result appears on o_value/o_status with o_valid high for one cycle, which the
// receiver cannot stall. A draw that finds the slot exhausted first regenerates
// it with one twist. Seeding writes the seed and then each further word in
// turn, pairing runs sum, multiply and add for each pair, then one twist
// (twenty for init). The single state memory with one write and two read
// ports and the shared 32x32 multiplier dictate this sequencing. Pop and
// unused codes go straight from decode to done. No clearing pass after reset.
module mersenne_twister_seed_stack_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_req_type,
    input  logic [31:0] i_seed_a,
    input  logic [31:0] i_seed_b,
    input  logic [31:0] i_seed_c,
    output logic [31:0] o_value,
    output logic        o_status,
    output logic        o_valid
);
    mts_pkg::t_cmd  cmd;
    mts_pkg::t_stat stat;

    mts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    mts_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_req_type (i_req_type),
        .i_seed_a   (i_seed_a),
        .i_seed_b   (i_seed_b),
        .i_seed_c   (i_seed_c),
        .o_value    (o_value),
        .o_status   (o_status),
        .o_valid    (o_valid)
    );
endmodule

// ===== rtl/mts_ctrl.sv =====
// Sequencing state machine for the seed stack.
// Depends on mts_pkg.
`timescale 1ns / 1ps
module mts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  mts_pkg::t_stat i_stat,
    output mts_pkg::t_cmd  o_cmd
);
    mts_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= mts_pkg::S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        busy = (r_state != mts_pkg::S_IDLE);
        case (r_state)
            mts_pkg::S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = mts_pkg::S_DECODE;
                end
            end
            mts_pkg::S_DECODE: begin
                o_cmd.decode = 1'b1;
                case (i_stat.req)
                    mts_pkg::REQ_DRAW: begin
                        n_state = i_stat.exhausted ? mts_pkg::S_TW_LD : mts_pkg::S_DRAW_RD;
                    end
                    mts_pkg::REQ_INIT, mts_pkg::REQ_PUSH1: n_state = mts_pkg::S_SEED_INIT;
                    mts_pkg::REQ_PUSH2, mts_pkg::REQ_PUSH3: n_state = mts_pkg::S_PAIR_SUM;
                    mts_pkg::REQ_POP: begin
                        o_cmd.pop = 1'b1;
                        n_state = mts_pkg::S_DONE;
                    end
                    default: n_state = mts_pkg::S_DONE;
                endcase
            end
            mts_pkg::S_PAIR_SUM: begin
                o_cmd.pair_sum = 1'b1;
                n_state = mts_pkg::S_PAIR_MUL;
            end
            mts_pkg::S_PAIR_MUL: begin
                o_cmd.pair_mul = 1'b1;
                n_state = mts_pkg::S_PAIR_ADD;
            end
            mts_pkg::S_PAIR_ADD: begin
                o_cmd.pair_add = 1'b1;
                n_state = i_stat.pair_again ? mts_pkg::S_PAIR_SUM : mts_pkg::S_SEED_INIT;
            end
            mts_pkg::S_SEED_INIT: begin
                o_cmd.seed_init = 1'b1;
                n_state = mts_pkg::S_SEED_MUL;
            end
            mts_pkg::S_SEED_MUL: begin
                o_cmd.seed_mul = 1'b1;
                n_state = mts_pkg::S_SEED_WR;
            end
            mts_pkg::S_SEED_WR: begin
                o_cmd.seed_wr = 1'b1;
                n_state = i_stat.idx_last ? mts_pkg::S_TW_LD : mts_pkg::S_SEED_MUL;
            end
            mts_pkg::S_TW_LD: begin
                o_cmd.tw_ld = 1'b1;
                n_state = mts_pkg::S_TW_CUR;
            end
            mts_pkg::S_TW_CUR: begin
                o_cmd.tw_cur = 1'b1;
                n_state = mts_pkg::S_TW_RD;
            end
            mts_pkg::S_TW_RD: begin
                o_cmd.tw_rd = 1'b1;
                n_state = mts_pkg::S_TW_WR;
            end
            mts_pkg::S_TW_WR: begin
                o_cmd.tw_wr = 1'b1;
                if (!i_stat.idx_last) n_state = mts_pkg::S_TW_RD;
                else if (!i_stat.twists_last) n_state = mts_pkg::S_TW_LD;
                else if (i_stat.req == mts_pkg::REQ_DRAW) begin
                    o_cmd.rp_clear = 1'b1;
                    n_state = mts_pkg::S_DRAW_RD;
                end else n_state = mts_pkg::S_DONE;
            end
            mts_pkg::S_DRAW_RD: begin
                o_cmd.draw_rd = 1'b1;
                n_state = mts_pkg::S_DRAW_OUT;
            end
            mts_pkg::S_DRAW_OUT: begin
                o_cmd.finish = 1'b1;
                o_cmd.finish_draw = 1'b1;
                n_state = mts_pkg::S_IDLE;
            end
            mts_pkg::S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = mts_pkg::S_IDLE;
            end
            default: n_state = mts_pkg::S_IDLE;
        endcase
    end
endmodule

// ===== rtl/mts_dp.sv =====
// Datapath: state word memory, seeding multiplier, twist logic, stack registers.
// Depends on mts_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "mersenne_twister_seed_stack_top_defines.svh"
module mts_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mts_pkg::t_cmd        i_cmd,
    output mts_pkg::t_stat       o_stat,
    input  logic [2:0]          i_req_type,
    input  logic [31:0]         i_seed_a,
    input  logic [31:0]         i_seed_b,
    input  logic [31:0]         i_seed_c,
    output logic [31:0]         o_value,
    output logic                o_status,
    output logic                o_valid
);
    localparam int MEM_WORDS = 1 << mts_pkg::ADDR_W;
    localparam int IW = mts_pkg::IDX_W;
    localparam int SW = mts_pkg::SLOT_W;

    logic [31:0] r_mem [0:MEM_WORDS-1];
    logic [31:0] r_rda, r_rdb;
    logic [2:0]  r_req;
    logic [31:0] r_a, r_b, r_c;
    logic        r_pass;
    logic [31:0] r_sum, r_prod, r_pair, r_prev, r_cur;
    logic [IW-1:0] r_idx;
    logic [SW-1:0] r_slot, r_active;
    logic [4:0]  r_twists;
    logic        r_ovf;
    logic [15:0] r_depth;
    logic [IW-1:0] r_rp [0:mts_pkg::STACK_SLOTS-1];
    logic        r_valid, r_status;
    logic [31:0] r_value;

    logic [mts_pkg::ADDR_W-1:0] addr_a, addr_b, waddr;
    logic        we;
    logic [31:0] wdata;
    logic [IW-1:0] idx_next, idx_far;
    logic [31:0] mix, y_tw, tw_word, mul_a, mul_b, pair_x, pair_y;
    logic [63:0] mul_full;
    logic [15:0] depth_push, depth_pop;
    logic [SW-1:0] push_slot;
    logic [31:0] seed_val;

    always_comb begin
        idx_next = (r_idx == IW'(mts_pkg::STATE_WORDS - 1)) ? '0 : r_idx + 1'b1;
        if ({1'b0, r_idx} + (IW+1)'(mts_pkg::SHIFT_OFS) >= (IW+1)'(mts_pkg::STATE_WORDS))
            idx_far = IW'({1'b0, r_idx} + (IW+1)'(mts_pkg::SHIFT_OFS)
                          - (IW+1)'(mts_pkg::STATE_WORDS));
        else idx_far = r_idx + IW'(mts_pkg::SHIFT_OFS);
        y_tw = (r_cur & mts_pkg::HI_MASK) | (r_rda & mts_pkg::LO_MASK);
        tw_word = r_rdb ^ (y_tw >> 1) ^ (y_tw[0] ? mts_pkg::TWIST_A : 32'd0);
        mix = r_prev ^ (r_prev >> 30);
        pair_x = r_pass ? r_pair : r_a;
        pair_y = r_pass ? r_c : r_b;
        mul_a = i_cmd.pair_mul ? r_sum : mix;
        mul_b = i_cmd.pair_mul ? r_sum + 32'd1 : mts_pkg::SEED_MUL;
        mul_full = {32'd0, mul_a} * {32'd0, mul_b};
        depth_push = (r_depth == mts_pkg::DEPTH_MAX) ? r_depth : r_depth + 16'd1;
        depth_pop = (r_depth != 16'd0) ? r_depth - 16'd1 : r_depth;
        push_slot = mts_pkg::clamp_slot(depth_push);
        seed_val = (r_req == mts_pkg::REQ_INIT || r_req == mts_pkg::REQ_PUSH1) ? r_a : r_pair;

        addr_a = {r_slot, idx_next};
        if (i_cmd.tw_ld) addr_a = {r_slot, IW'(0)};
        else if (i_cmd.draw_rd) addr_a = {r_slot, r_rp[r_slot]};
        addr_b = {r_slot, idx_far};

        we = 1'b0;
        waddr = {r_slot, r_idx};
        wdata = tw_word;
        if (i_cmd.seed_init) begin
            we = 1'b1;
            waddr = {(r_req == mts_pkg::REQ_INIT) ? SW'(0) : push_slot, IW'(0)};
            wdata = seed_val;
        end else if (i_cmd.seed_wr) begin
            we = 1'b1;
            wdata = r_prod + {{(32-IW){1'b0}}, r_idx};
        end else if (i_cmd.tw_wr) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        r_rda <= r_mem[addr_a];
        r_rdb <= r_mem[addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_a <= i_seed_a;
            r_b <= i_seed_b;
            r_c <= i_seed_c;
        end
        if (i_cmd.pair_sum) r_sum <= pair_x + pair_y;
        if (i_cmd.pair_mul || i_cmd.seed_mul) r_prod <= mul_full[31:0];
        if (i_cmd.pair_add) r_pair <= r_prod + {pair_y[30:0], 1'b0};
        if (i_cmd.seed_init) r_prev <= seed_val;
        if (i_cmd.seed_wr) r_prev <= wdata;
        if (i_cmd.tw_cur || i_cmd.tw_wr) r_cur <= r_rda;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_depth <= '0;
            r_valid <= 1'b0;
            r_status <= 1'b0;
            r_value <= '0;
            r_idx <= '0;
            r_pass <= 1'b0;
            r_ovf <= 1'b0;
            r_slot <= '0;
            r_twists <= 5'd1;
            for (int k = 0; k < mts_pkg::STACK_SLOTS; k++)
                r_rp[k] <= IW'(mts_pkg::STATE_WORDS);
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.finish) begin
                r_value <= i_cmd.finish_draw ? r_rda : 32'd0;
                r_status <= r_ovf;
            end
            if (i_cmd.load) begin
                r_pass <= 1'b0;
                r_ovf <= 1'b0;
                r_twists <= 5'd1;
                r_idx <= '0;
            end
            if (i_cmd.decode) r_slot <= r_active;
            if (i_cmd.pop) begin
                r_depth <= depth_pop;
                r_active <= mts_pkg::clamp_slot(depth_pop);
            end
            if (i_cmd.pair_add) r_pass <= 1'b1;
            if (i_cmd.seed_init) begin
                r_idx <= IW'(1);
                if (r_req == mts_pkg::REQ_INIT) begin
                    r_slot <= '0;
                    r_active <= '0;
                    r_depth <= '0;
                    r_twists <= 5'(mts_pkg::INIT_TWISTS);
                    r_rp[0] <= IW'(mts_pkg::STATE_WORDS);
                end else begin
                    r_slot <= push_slot;
                    r_active <= push_slot;
                    r_depth <= depth_push;
                    r_ovf <= (depth_push >= 16'(mts_pkg::STACK_SLOTS));
                    r_rp[push_slot] <= IW'(mts_pkg::STATE_WORDS);
                end
            end
            if (i_cmd.seed_wr) r_idx <= idx_next;
            if (i_cmd.tw_ld) r_idx <= '0;
            if (i_cmd.tw_wr) begin
                r_idx <= idx_next;
                if (r_idx == IW'(mts_pkg::STATE_WORDS - 1)) r_twists <= r_twists - 5'd1;
            end
            if (i_cmd.rp_clear) r_rp[r_slot] <= '0;
            if (i_cmd.draw_rd) r_rp[r_slot] <= r_rp[r_slot] + 1'b1;
        end
    end

    always_comb begin
        o_stat.req = r_req;
        o_stat.exhausted = (r_rp[r_active] >= IW'(mts_pkg::STATE_WORDS));
        o_stat.pair_again = (r_req == mts_pkg::REQ_PUSH3) && !r_pass;
        o_stat.idx_last = (r_idx == IW'(mts_pkg::STATE_WORDS - 1));
        o_stat.twists_last = (r_twists == 5'd1);
    end

    assign o_value = r_value;
    assign o_status = r_status;
    assign o_valid = r_valid;

    // result strobe lasts one cycle
    `MTS_ASSERT_NEXT(a_strobe_single, i_clk, i_rst_n, r_valid, !r_valid)
    `MTS_ASSERT_IMPLY(a_active_tracks_depth, i_clk, i_rst_n,
        r_depth < 16'(mts_pkg::STACK_SLOTS), r_active == r_depth[SW-1:0])
    `MTS_ASSERT_IMPLY(a_idx_range, i_clk, i_rst_n,
        1'b1, r_idx < IW'(mts_pkg::STATE_WORDS))
endmodule

// ===== test/tb_mersenne_twister_seed_stack_top.sv =====
// Self-checking testbench for the untempered MT19937 seed stack top level.
// Depends on mts_pkg and mersenne_twister_seed_stack_top; predicts every
// transaction with its own generator-stack model and compares each result.
`timescale 1ns / 1ps
module tb_mersenne_twister_seed_stack_top;
    localparam logic [2:0] REQ_SPARE6 = 3'd6;
    localparam logic [2:0] REQ_SPARE7 = 3'd7;
    localparam int RANDOM_ITEMS = 1625;
    localparam int QUIET_TAIL = 150;
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int NW = mts_pkg::STATE_WORDS;
    localparam int NS = mts_pkg::STACK_SLOTS;

    typedef struct {
        logic [2:0]  req;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_request;

    typedef struct {
        logic [31:0] value;
        logic        status;
    } t_response;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_req_type = mts_pkg::REQ_DRAW;
    logic [31:0] i_seed_a = '0;
    logic [31:0] i_seed_b = '0;
    logic [31:0] i_seed_c = '0;
    logic [31:0] o_value;
    logic        o_status;
    logic        o_valid;

    t_request  pending_reqs[$];
    t_response expected_resps[$];
    bit        stim_filled = 1'b0;
    bit        taken = 1'b0;
    int        gap_left = 0;
    int        err_count = 0;
    longint    cycles = 0;

    logic [31:0] gen_words[NS][NW];
    int          gen_pos[NS];
    int          gen_slot;
    int          gen_depth;

    mersenne_twister_seed_stack_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_seed_a(i_seed_a), .i_seed_b(i_seed_b),
        .i_seed_c(i_seed_c), .o_value(o_value), .o_status(o_status),
        .o_valid(o_valid)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [31:0] cantor_mix(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] s;
        s = x + y;
        return s * (s + 32'd1) + (y << 1);
    endfunction

    function automatic int slot_of(input int depth);
        return (depth >= NS) ? NS - 1 : depth;
    endfunction

    task automatic twist_state(input int slot);
        logic [31:0] y;
        for (int i = 0; i < NW; i++) begin
            y = (gen_words[slot][i] & mts_pkg::HI_MASK)
                | (gen_words[slot][(i + 1) % NW] & mts_pkg::LO_MASK);
            gen_words[slot][i] = gen_words[slot][(i + mts_pkg::SHIFT_OFS) % NW]
                ^ (y >> 1) ^ (y[0] ? mts_pkg::TWIST_A : 32'd0);
        end
    endtask

    task automatic seed_state(input int slot, input logic [31:0] seed);
        logic [31:0] p;
        gen_words[slot][0] = seed;
        for (int i = 1; i < NW; i++) begin
            p = gen_words[slot][i-1];
            gen_words[slot][i] = mts_pkg::SEED_MUL * (p ^ (p >> 30)) + 32'(i);
        end
        gen_pos[slot] = NW;
    endtask

    task automatic push_state(input logic [31:0] seed, output logic ovf);
        if (gen_depth < int'(mts_pkg::DEPTH_MAX)) gen_depth++;
        gen_slot = slot_of(gen_depth);
        seed_state(gen_slot, seed);
        twist_state(gen_slot);
        ovf = (gen_depth >= NS);
    endtask

    task automatic predict_response(input t_request r, output t_response e);
        e.value = '0;
        e.status = 1'b0;
        case (r.req)
            mts_pkg::REQ_DRAW: begin
                if (gen_pos[gen_slot] >= NW) begin
                    twist_state(gen_slot);
                    gen_pos[gen_slot] = 0;
                end
                e.value = gen_words[gen_slot][gen_pos[gen_slot]];
                gen_pos[gen_slot]++;
            end
            mts_pkg::REQ_INIT: begin
                gen_slot = 0;
                gen_depth = 0;
                seed_state(0, r.a);
                for (int k = 0; k < mts_pkg::INIT_TWISTS; k++) twist_state(0);
            end
            mts_pkg::REQ_PUSH1: push_state(r.a, e.status);
            mts_pkg::REQ_PUSH2: push_state(cantor_mix(r.a, r.b), e.status);
            mts_pkg::REQ_PUSH3: push_state(cantor_mix(cantor_mix(r.a, r.b), r.c), e.status);
            mts_pkg::REQ_POP: begin
                if (gen_depth > 0) gen_depth--;
                gen_slot = slot_of(gen_depth);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        err_count++;
    endtask

    // Monitor: check results, then record newly accepted transactions
    always @(posedge i_clk) begin
        t_response e;
        t_request  r;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid) begin
                if (expected_resps.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    e = expected_resps.pop_front();
                    if (o_value !== e.value)
                        report_mismatch($sformatf("value %h, expected %h", o_value, e.value));
                    if (o_status !== e.status)
                        report_mismatch($sformatf("status %b, expected %b", o_status, e.status));
                end
            end
            if (start && !busy) begin
                r.req = i_req_type;
                r.a = i_seed_a;
                r.b = i_seed_b;
                r.c = i_seed_c;
                predict_response(r, e);
                expected_resps.push_back(e);
                taken = 1'b1;
            end
        end
    end

    // Driver
    always @(negedge i_clk) begin
        t_request r;
        bit       quiet;
        if (i_rst_n && (!start || taken)) begin
            taken = 1'b0;
            quiet = stim_filled && pending_reqs.size() < QUIET_TAIL;
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                start <= 1'b0;
            end else if (!quiet && $urandom_range(7) == 0) begin
                gap_left = $urandom_range(18);
                start <= 1'b0;
            end else begin
                r = pending_reqs.pop_front();
                i_req_type <= r.req;
                i_seed_a <= r.a;
                i_seed_b <= r.b;
                i_seed_c <= r.c;
                start <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_seed();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'hFFFFFFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic add_req(input logic [2:0] req, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c);
        t_request r;
        r.req = req;
        r.a = a;
        r.b = b;
        r.c = c;
        pending_reqs.push_back(r);
    endtask

    task automatic add_push();
        logic [2:0] kind;
        kind = mts_pkg::REQ_PUSH1 + 3'($urandom_range(2));
        add_req(kind, pick_seed(), pick_seed(), pick_seed());
    endtask

    initial begin
        int n;
        int w;
        for (int k = 0; k < NS; k++) gen_pos[k] = NW;
        gen_slot = 0;
        gen_depth = 0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: init first so slot 0 is never read unseeded
        add_req(mts_pkg::REQ_INIT, 32'hFFFFFFFF, 32'h0, 32'h0);
        add_req(mts_pkg::REQ_DRAW, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_req(mts_pkg::REQ_DRAW, 32'h0, 32'h0, 32'h0);
        add_req(mts_pkg::REQ_PUSH1, 32'h0, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_req(mts_pkg::REQ_DRAW, 32'h0, 32'h0, 32'h0);
        add_req(mts_pkg::REQ_PUSH2, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0);
        add_req(mts_pkg::REQ_PUSH3, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_req(mts_pkg::REQ_DRAW, 32'h0, 32'h0, 32'h0);
        add_req(mts_pkg::REQ_PUSH3, 32'h0, 32'h0, 32'h0);
        add_req(REQ_SPARE6, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        add_req(REQ_SPARE7, 32'h0, 32'h0, 32'h0);
        for (int k = 0; k < 5; k++) add_req(mts_pkg::REQ_POP, 32'h0, 32'h0, 32'h0);
        add_req(mts_pkg::REQ_DRAW, 32'h0, 32'h0, 32'h0);
        add_req(mts_pkg::REQ_INIT, 32'h0, 32'h0, 32'h0);
        add_req(mts_pkg::REQ_DRAW, 32'h0, 32'h0, 32'h0);

        // Random: mostly draws, with two deep dives past the top slot
        n = 0;
        while (n < RANDOM_ITEMS) begin
            if (n == 400 || n == 1200) begin
                for (int k = 0; k < 18; k++) begin
                    add_push();
                    if ($urandom_range(3) == 0)
                        add_req(mts_pkg::REQ_DRAW, $urandom(), $urandom(), $urandom());
                end
                for (int k = 0; k < 19; k++) begin
                    add_req(mts_pkg::REQ_POP, $urandom(), $urandom(), $urandom());
                    if ($urandom_range(3) == 0)
                        add_req(mts_pkg::REQ_DRAW, $urandom(), $urandom(), $urandom());
                end
                n += 37;
            end else begin
                w = $urandom_range(999);
                if (w < 860) add_req(mts_pkg::REQ_DRAW, $urandom(), $urandom(), $urandom());
                else if (w < 900) add_push();
                else if (w < 960) add_req(mts_pkg::REQ_POP, $urandom(), $urandom(), $urandom());
                else if (w < 963) add_req(mts_pkg::REQ_INIT, pick_seed(), $urandom(), $urandom());
                else if (w < 980) add_req(REQ_SPARE6, $urandom(), $urandom(), $urandom());
                else add_req(REQ_SPARE7, $urandom(), $urandom(), $urandom());
                n++;
            end
        end
        stim_filled = 1'b1;

        do @(posedge i_clk);
        while (pending_reqs.size() != 0 || start || expected_resps.size() != 0);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
